[rtl/core/psis_pkg.sv]
`timescale 1ns / 1ps
// shared constants and sequencer state type for the prime subset sorter
package psis_pkg;

	// width of the value fields on the ports
	localparam int IO_W = 16;

	// parameter defaults
	localparam int MAX_LEN_DEF    = 64;
	localparam int VALUE_BITS_DEF = 16;

	// sequencer states, one-hot
	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_PSQ   = 10'b00_0000_0010,
		S_PDIV  = 10'b00_0000_0100,
		S_SPASS = 10'b00_0000_1000,
		S_SRD   = 10'b00_0001_0000,
		S_SCMP  = 10'b00_0010_0000,
		S_SEND  = 10'b00_0100_0000,
		S_ERD   = 10'b00_1000_0000,
		S_ELD   = 10'b01_0000_0000,
		S_EOUT  = 10'b10_0000_0000
	} state_t;

endpackage

[rtl/core/psis_alu.sv]
`timescale 1ns / 1ps
// shared subtract and compare unit
module psis_alu #(
	parameter int W = 18
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         ge,
	output logic [W-1:0] diff
);

	logic [W:0] full;

	// borrow out of the top tells a < b
	assign full = {1'b0, a} - {1'b0, b};
	assign ge   = ~full[W];
	assign diff = full[W-1:0];

endmodule

[rtl/core/psis_mem.sv]
`timescale 1ns / 1ps
// element store, one write port and one registered read port
module psis_mem #(
	parameter int DEPTH = 64,
	parameter int W     = 17,
	parameter int AIW   = 6
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AIW-1:0] waddr,
	input  logic [W-1:0]   wdata,
	input  logic [AIW-1:0] raddr,
	output logic [W-1:0]   rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/prime_subset_in_place_sorter.sv]
`timescale 1ns / 1ps
// top level: load, primality test, in-place sort of the primes, emission
//
// input channel (in_valid/in_ready, value, is_last): one beat per array element;
//   is_last closes the array. in_ready is high only while the sequencer is idle.
// each stored element is tested for primality right after its beat by trial
//   division through one shared subtract/compare unit: a square check per divisor
//   (S_PSQ), then a restoring remainder step per value bit (S_PDIV), for the
//   divisor 2 and then the odd divisors 3, 5, 7 and on up to the square root.
// after the last beat, bubble passes over the store move the primes into
//   ascending order among their own positions; passes repeat until one makes
//   no swap (at most one more than the primes).
// output channel (out_valid/out_ready, value_res, is_last_res, overflow): one
//   beat per stored element in array order, held while out_ready is low and
//   taken before the next is read; is_last_res marks the final beat, overflow is
//   set on every beat of an array of more than MAX_LEN elements (extra dropped).
// reset clears the element count and the overflow flag; the store itself
//   needs no clearing since only entries written for the current array are read.
module prime_subset_in_place_sorter
	import psis_pkg::*;
#(
	parameter int MAX_LEN    = MAX_LEN_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [IO_W-1:0] value,
	input  logic            is_last,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [IO_W-1:0] value_res,
	output logic            is_last_res,
	output logic            overflow
);

	// stored value width: the port limits it to IO_W bits
	localparam int SW  = (VALUE_BITS < IO_W) ? VALUE_BITS : IO_W;
	// divisor width, holds the first divisor past the square root
	localparam int DW  = (SW + 1) / 2 + 1;
	// shared unit width, holds a divisor squared
	localparam int AW  = 2 * DW;
	localparam int BW  = $clog2(SW);
	localparam int AIW = $clog2(MAX_LEN);
	localparam int CW  = $clog2(MAX_LEN + 1);

	state_t state_q;

	logic [CW-1:0]  cnt_q;
	logic           ovf_q;
	logic           last_q;

	// primality test registers
	logic [SW-1:0]  num_q;
	logic [DW-1:0]  d_q;
	logic [DW-1:0]  rem_q;
	logic [BW-1:0]  bit_q;

	// sort and emission registers
	logic [AIW-1:0] idx_q;
	logic [AIW-1:0] prev_q;
	logic [SW-1:0]  held_q;
	logic           has_q;
	logic           swap_q;

	logic            out_valid_q;
	logic [IO_W-1:0] value_res_q;
	logic            is_last_res_q;
	logic            overflow_q;

	// shared unit
	logic [AW-1:0] alu_a;
	logic [AW-1:0] alu_b;
	logic          alu_ge;
	logic [AW-1:0] alu_diff;

	// store ports
	logic           mem_we;
	logic [AIW-1:0] mem_waddr;
	logic [SW:0]    mem_wdata;
	logic [AIW-1:0] mem_raddr;
	logic [SW:0]    mem_rdata;

	logic [AW-1:0]  sq;
	logic [DW:0]    sh;
	logic [DW-1:0]  rem_nx;
	logic [DW-1:0]  d_nx;
	logic           num_lt2;
	logic [SW-1:0]  cur;
	logic           cur_mk;
	logic [CW-1:0]  cnt_m1;
	logic [AIW-1:0] last_idx;
	logic           at_last;

	psis_alu #(
		.W(AW)
	) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.ge  (alu_ge),
		.diff(alu_diff)
	);

	// element value in the low bits, prime mark on top
	psis_mem #(
		.DEPTH(MAX_LEN),
		.W    (SW + 1),
		.AIW  (AIW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign sq       = AW'(d_q) * AW'(d_q);
	assign sh       = {rem_q, num_q[bit_q]};
	assign rem_nx   = alu_ge ? alu_diff[DW-1:0] : sh[DW-1:0];
	// after 2 only odd divisors are needed
	assign d_nx     = (d_q == DW'(2)) ? DW'(3) : d_q + DW'(2);
	assign num_lt2  = (num_q[SW-1:1] == '0);
	assign cur      = mem_rdata[SW-1:0];
	assign cur_mk   = mem_rdata[SW];
	assign cnt_m1   = cnt_q - CW'(1);
	assign last_idx = cnt_m1[AIW-1:0];
	assign at_last  = (idx_q == last_idx);
	assign mem_raddr = idx_q;

	// operand selection and store writes
	always_comb begin
		alu_a     = '0;
		alu_b     = '0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AIW-1:0];
		mem_wdata = {1'b0, num_q};
		unique case (state_q)
			S_PSQ: begin
				// value >= divisor squared keeps the search going
				alu_a = AW'(num_q);
				alu_b = sq;
				if (num_lt2) begin
					mem_we = 1'b1;
				end else if (!alu_ge) begin
					mem_we    = 1'b1;
					mem_wdata = {1'b1, num_q};
				end
			end
			S_PDIV: begin
				// one restoring remainder step
				alu_a = AW'(sh);
				alu_b = AW'(d_q);
				if (bit_q == '0 && rem_nx == '0) begin
					mem_we = 1'b1;
				end
			end
			S_SCMP: begin
				// carried value against the next prime; the smaller lands behind
				alu_a = AW'(cur);
				alu_b = AW'(held_q);
				if (cur_mk && has_q) begin
					mem_we    = 1'b1;
					mem_waddr = prev_q;
					mem_wdata = alu_ge ? {1'b1, held_q} : {1'b1, cur};
				end
			end
			S_SEND: begin
				// largest of the pass goes to the last prime position
				if (has_q) begin
					mem_we    = 1'b1;
					mem_waddr = prev_q;
					mem_wdata = {1'b1, held_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (cnt_q < CW'(MAX_LEN)) begin
							num_q   <= value[SW-1:0];
							last_q  <= is_last;
							d_q     <= DW'(2);
							state_q <= S_PSQ;
						end else begin
							// store full, beat dropped
							ovf_q <= 1'b1;
							if (is_last) begin
								state_q <= S_SPASS;
							end
						end
					end
				end
				S_PSQ: begin
					if (num_lt2 || !alu_ge) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= last_q ? S_SPASS : S_IDLE;
					end else begin
						rem_q   <= '0;
						bit_q   <= BW'(SW - 1);
						state_q <= S_PDIV;
					end
				end
				S_PDIV: begin
					rem_q <= rem_nx;
					if (bit_q == '0) begin
						if (rem_nx == '0) begin
							cnt_q   <= cnt_q + CW'(1);
							state_q <= last_q ? S_SPASS : S_IDLE;
						end else begin
							d_q     <= d_nx;
							state_q <= S_PSQ;
						end
					end else begin
						bit_q <= bit_q - BW'(1);
					end
				end
				S_SPASS: begin
					idx_q   <= '0;
					has_q   <= 1'b0;
					swap_q  <= 1'b0;
					state_q <= S_SRD;
				end
				S_SRD: begin
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (cur_mk) begin
						has_q  <= 1'b1;
						prev_q <= idx_q;
						if (!has_q || alu_ge) begin
							held_q <= cur;
						end else begin
							swap_q <= 1'b1;
						end
					end
					if (at_last) begin
						state_q <= S_SEND;
					end else begin
						idx_q   <= idx_q + AIW'(1);
						state_q <= S_SRD;
					end
				end
				S_SEND: begin
					if (swap_q) begin
						state_q <= S_SPASS;
					end else begin
						idx_q   <= '0;
						state_q <= S_ERD;
					end
				end
				S_ERD: begin
					state_q <= S_ELD;
				end
				S_ELD: begin
					value_res_q   <= IO_W'(cur);
					is_last_res_q <= at_last;
					overflow_q    <= ovf_q;
					out_valid_q   <= 1'b1;
					state_q       <= S_EOUT;
				end
				S_EOUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (at_last) begin
							// array done, ready for the next one
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + AIW'(1);
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign value_res   = value_res_q;
	assign is_last_res = is_last_res_q;
	assign overflow    = overflow_q;

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result beat is pending");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_LEN))
		else $error("element count beyond store depth");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (cnt_q == CW'(MAX_LEN)))
		else $error("overflow flagged with store not full");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && is_last_res) |=> (cnt_q == '0 && !ovf_q && in_ready))
		else $error("array state not cleared after final beat");
`endif

endmodule

[tb/sv/prime_subset_in_place_sorter_tb.sv]
`timescale 1ns / 1ps
// testbench for the prime subset sorter: directed table, random arrays, self-checking predictor
module prime_subset_in_place_sorter_tb
	import psis_pkg::*;
();

	// store depth of the block under its default parameters
	localparam int DEPTH = MAX_LEN_DEF;
	// quiet cycles tolerated: several times the worst quiet stretch, the sort of a full store
	// of large primes, which outlasts the primality test of a single large prime
	localparam int QUIET_LIMIT = 60000;
	// cycles allowed after the last result for the sequencer to fall back to idle
	localparam int SETTLE = 40;
	// rough number of input beats in the whole run
	localparam int ITEM_GOAL = 200;
	// from this many beats on, neither side idles
	localparam int CALM_AFTER = 172;

	typedef struct packed {
		logic [IO_W-1:0] v;
		logic            lst;
		logic            ovf;
	} beat_t;

	// one row of the directed table; want is only used where typed is set
	typedef struct packed {
		logic [IO_W-1:0] v;
		logic            lst;
		logic            typed;
		logic [IO_W-1:0] want;
	} row_t;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [IO_W-1:0] value;
	logic            is_last;
	logic            out_valid;
	logic            out_ready;
	logic [IO_W-1:0] value_res;
	logic            is_last_res;
	logic            overflow;

	// predictor state: the array as the block should hold it
	logic [IO_W-1:0] held_vals [DEPTH];
	bit              held_prime [DEPTH];
	int unsigned     held_count;
	bit              dropped_any;

	// results still owed by the block, oldest first
	beat_t awaited [$];

	int  errors;
	int  sent;
	bit  calm;
	int  stall_left;

	// directed table: lone elements first (results can be typed in), then short arrays
	// whose sorted order comes from the predictor
	row_t plan [0:24] = '{
		// lone zero and one are not prime, two is the smallest prime
		'{16'd0,     1'b1, 1'b1, 16'd0},
		'{16'd1,     1'b1, 1'b1, 16'd1},
		'{16'd2,     1'b1, 1'b1, 16'd2},
		// all ones is composite, 65521 is the largest 16-bit prime (longest trial division)
		'{16'd65535, 1'b1, 1'b1, 16'd65535},
		'{16'd65521, 1'b1, 1'b1, 16'd65521},
		// primes scattered between composites, out of order
		'{16'd13,    1'b0, 1'b0, 16'd0},
		'{16'd4,     1'b0, 1'b0, 16'd0},
		'{16'd7,     1'b0, 1'b0, 16'd0},
		'{16'd65521, 1'b0, 1'b0, 16'd0},
		'{16'd1,     1'b0, 1'b0, 16'd0},
		'{16'd2,     1'b0, 1'b0, 16'd0},
		'{16'd9,     1'b1, 1'b0, 16'd0},
		// equal primes, ties must stay put
		'{16'd5,     1'b0, 1'b0, 16'd0},
		'{16'd0,     1'b0, 1'b0, 16'd0},
		'{16'd3,     1'b0, 1'b0, 16'd0},
		'{16'd5,     1'b0, 1'b0, 16'd0},
		'{16'd3,     1'b1, 1'b0, 16'd0},
		// no primes at all, array comes back untouched
		'{16'd65535, 1'b0, 1'b0, 16'd0},
		'{16'd0,     1'b0, 1'b0, 16'd0},
		'{16'd32768, 1'b0, 1'b0, 16'd0},
		'{16'd4,     1'b1, 1'b0, 16'd0},
		// square of a prime next to primes in descending order
		'{16'd49,    1'b0, 1'b0, 16'd0},
		'{16'd65521, 1'b0, 1'b0, 16'd0},
		'{16'd251,   1'b0, 1'b0, 16'd0},
		'{16'd3,     1'b1, 1'b0, 16'd0}
	};

	prime_subset_in_place_sorter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value_res  (value_res),
		.is_last_res(is_last_res),
		.overflow   (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// trial division, 0 and 1 excluded
	function automatic bit is_prime(input logic [IO_W-1:0] n);
		int unsigned d;
		if (n < 2)
			return 1'b0;
		for (d = 2; d * d <= n; d++)
			if (n % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	// mostly small values so primes and ties are common, some full range and edge values
	function automatic logic [IO_W-1:0] pick_value();
		case ($urandom_range(0, 9)) inside
			[0:3]: pick_value = IO_W'($urandom_range(0, 63));
			[4:5]: pick_value = IO_W'($urandom_range(0, 1023));
			[6:8]: pick_value = IO_W'($urandom);
			default: begin
				case ($urandom_range(0, 4))
					0:       pick_value = 16'd0;
					1:       pick_value = 16'd1;
					2:       pick_value = 16'd2;
					3:       pick_value = 16'd65521;
					default: pick_value = 16'd65535;
				endcase
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [IO_W-1:0] got,
			input logic [IO_W-1:0] wanted);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, wanted);
		errors++;
	endtask

	// takes one accepted beat into the predictor; a closing beat sorts the primes among
	// their own positions and queues the whole array as expected results
	task automatic take_element(input logic [IO_W-1:0] v, input logic lst, input logic typed,
			input logic [IO_W-1:0] want);
		int unsigned     spots [$];
		int unsigned     n;
		logic [IO_W-1:0] swap;
		// a full store drops the beat, even a closing one, and marks the array
		if (held_count < DEPTH) begin
			held_vals[held_count]  = v;
			held_prime[held_count] = is_prime(v);
			held_count++;
		end else begin
			dropped_any = 1'b1;
		end
		if (!lst)
			return;
		n = held_count;
		for (int i = 0; i < n; i++)
			if (held_prime[i])
				spots.push_back(i);
		// compare-swap passes over prime positions; equal primes never move
		for (int p = 0; p + 1 < spots.size(); p++) begin
			for (int q = 0; q + 1 < spots.size(); q++) begin
				if (held_vals[spots[q]] > held_vals[spots[q + 1]]) begin
					swap                  = held_vals[spots[q]];
					held_vals[spots[q]]   = held_vals[spots[q + 1]];
					held_vals[spots[q + 1]] = swap;
				end
			end
		end
		// typed rows are lone elements, so their single result is written out by hand
		if (typed)
			awaited.push_back(beat_t'{want, 1'b1, 1'b0});
		else
			for (int i = 0; i < n; i++)
				awaited.push_back(beat_t'{held_vals[i], i + 1 == n, dropped_any});
		held_count  = 0;
		dropped_any = 1'b0;
	endtask

	// one input beat, with an optional idle burst in front of it
	task automatic send_element(input logic [IO_W-1:0] v, input logic lst, input logic typed,
			input logic [IO_W-1:0] want);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		is_last  <= lst;
		do @(posedge clk); while (!in_ready);
		sent++;
		calm = sent >= CALM_AFTER;
		take_element(v, lst, typed, want);
	endtask

	// compares one output beat with the oldest expectation
	task automatic check_beat();
		beat_t want;
		if (awaited.size() == 0) begin
			report_mismatch("value_res, nothing awaited", value_res, '0);
			return;
		end
		want = awaited.pop_front();
		if (value_res !== want.v)
			report_mismatch("value_res", value_res, want.v);
		if (is_last_res !== want.lst)
			report_mismatch("is_last_res", IO_W'(is_last_res), IO_W'(want.lst));
		if (overflow !== want.ovf)
			report_mismatch("overflow", IO_W'(overflow), IO_W'(want.ovf));
	endtask

	// result side: check on every accepted beat, stall in short random bursts until calm
	initial begin
		out_ready  <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_beat();
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 3) - 1;
				out_ready  <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog: ends the run after too long without any beat on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("prime_subset_in_place_sorter_tb NOT OK");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int k;
		int e;
		int len;
		errors      = 0;
		sent        = 0;
		calm        = 1'b0;
		held_count  = 0;
		dropped_any = 1'b0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		value    <= '0;
		is_last  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int r = 0; r < $size(plan); r++)
			send_element(plan[r].v, plan[r].lst, plan[r].typed, plan[r].want);

		// random arrays: mostly short, one that fills the store exactly, and one that
		// runs two past it so the closing beat itself is dropped
		for (k = 0; sent < ITEM_GOAL || k < 6; k++) begin
			len = (k == 2) ? DEPTH : (k == 5) ? DEPTH + 2 : $urandom_range(1, 8);
			for (e = 0; e < len; e++)
				send_element(pick_value(), e == len - 1, 1'b0, '0);
		end
		in_valid <= 1'b0;

		// drain the results, then give the sequencer time to return to idle
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("prime_subset_in_place_sorter_tb OK");
		else
			$display("prime_subset_in_place_sorter_tb NOT OK");
		$finish;
	end

endmodule
